// File: design/oriented_box_overlap_test_assert.svh
// Assertion macros for the oriented box overlap test.
`ifndef ORIENTED_BOX_OVERLAP_TEST_ASSERT_SVH
`define ORIENTED_BOX_OVERLAP_TEST_ASSERT_SVH

// Same-cycle implication.
`define OBOT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define OBOT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/obot_pkg.sv
`timescale 1ns / 1ps

package obot_pkg;

  localparam int unsigned CenterW = 24;
  localparam int unsigned RotW    = 16;
  localparam int unsigned ExtW    = 22;
  localparam int unsigned NumAx   = 4;
  localparam int unsigned NumBox  = 2;
  localparam int unsigned FracSh  = 14;

  localparam int unsigned AxW     = RotW + 1;             // negated sine needs one more bit
  localparam int unsigned DiffW   = CenterW + 1;
  localparam int unsigned DotW    = RotW + AxW + 1;
  localparam int unsigned DistW   = DiffW + AxW + 1;
  localparam int unsigned ProdW   = DotW + ExtW + 1;
  localparam int unsigned MagW    = ProdW - 1;
  localparam int unsigned AbsDW   = DistW - 1;
  localparam int unsigned RadW    = MagW + 2;
  localparam int unsigned Latency = 6;

  typedef logic signed [CenterW-1:0] center_t;
  typedef logic signed [RotW-1:0]    rot_t;
  typedef logic        [ExtW-1:0]    ext_t;
  typedef logic signed [AxW-1:0]     axis_t;
  typedef logic signed [DiffW-1:0]   diff_t;
  typedef logic signed [DotW-1:0]    dot_t;
  typedef logic signed [DistW-1:0]   dist_t;
  typedef logic signed [ProdW-1:0]   prod_t;
  typedef logic        [MagW-1:0]    mag_t;
  typedef logic        [AbsDW-1:0]   absd_t;
  typedef logic        [RadW-1:0]    rad_t;

endpackage

// File: design/oriented_box_overlap_test.sv
// Throughput: one box pair per cycle; busy is always low.
// Six register stages: axes, dot products, extent multiplies, magnitudes,
// radius sums, compare. The result register is the last stage.
// Reset (rst_ni low, asynchronous) clears the stage valid bits; no strobe follows.
`timescale 1ns / 1ps

module oriented_box_overlap_test (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  obot_pkg::center_t       first_center_x_i,
  input  obot_pkg::center_t       first_center_y_i,
  input  obot_pkg::rot_t          first_cosine_i,
  input  obot_pkg::rot_t          first_sine_i,
  input  obot_pkg::ext_t          first_half_width_i,
  input  obot_pkg::ext_t          first_half_height_i,
  input  obot_pkg::center_t       second_center_x_i,
  input  obot_pkg::center_t       second_center_y_i,
  input  obot_pkg::rot_t          second_cosine_i,
  input  obot_pkg::rot_t          second_sine_i,
  input  obot_pkg::ext_t          second_half_width_i,
  input  obot_pkg::ext_t          second_half_height_i,
  output logic                    done_o,
  output logic                    boxes_overlap_o
);

`include "oriented_box_overlap_test_assert.svh"

  localparam int unsigned NA = obot_pkg::NumAx;
  localparam int unsigned NB = obot_pkg::NumBox;

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // stage 1: axes, center difference
  logic              s1_valid_q;
  obot_pkg::diff_t   s1_dx_q, s1_dy_q;
  obot_pkg::axis_t   s1_ax_q [NA];
  obot_pkg::axis_t   s1_ay_q [NA];
  obot_pkg::rot_t    s1_c_q  [NB];
  obot_pkg::rot_t    s1_s_q  [NB];
  obot_pkg::ext_t    s1_w_q  [NB];
  obot_pkg::ext_t    s1_h_q  [NB];

  obot_pkg::axis_t   s1_ax_d [NA];
  obot_pkg::axis_t   s1_ay_d [NA];

  always_comb begin
    obot_pkg::axis_t c1, s1, c2, s2;
    c1 = obot_pkg::AxW'(first_cosine_i);
    s1 = obot_pkg::AxW'(first_sine_i);
    c2 = obot_pkg::AxW'(second_cosine_i);
    s2 = obot_pkg::AxW'(second_sine_i);
    s1_ax_d[0] = (first_half_width_i   != '0) ? c1  : '0;
    s1_ay_d[0] = (first_half_width_i   != '0) ? s1  : '0;
    s1_ax_d[1] = (first_half_height_i  != '0) ? -s1 : '0;
    s1_ay_d[1] = (first_half_height_i  != '0) ? c1  : '0;
    s1_ax_d[2] = (second_half_width_i  != '0) ? c2  : '0;
    s1_ay_d[2] = (second_half_width_i  != '0) ? s2  : '0;
    s1_ax_d[3] = (second_half_height_i != '0) ? -s2 : '0;
    s1_ay_d[3] = (second_half_height_i != '0) ? c2  : '0;
  end

  always_ff @(posedge clk_i) begin
    s1_dx_q   <= obot_pkg::DiffW'(first_center_x_i) - obot_pkg::DiffW'(second_center_x_i);
    s1_dy_q   <= obot_pkg::DiffW'(first_center_y_i) - obot_pkg::DiffW'(second_center_y_i);
    s1_ax_q   <= s1_ax_d;
    s1_ay_q   <= s1_ay_d;
    s1_c_q[0] <= first_cosine_i;
    s1_s_q[0] <= first_sine_i;
    s1_w_q[0] <= first_half_width_i;
    s1_h_q[0] <= first_half_height_i;
    s1_c_q[1] <= second_cosine_i;
    s1_s_q[1] <= second_sine_i;
    s1_w_q[1] <= second_half_width_i;
    s1_h_q[1] <= second_half_height_i;
  end

  // stage 2: edge vector directions and center offset projected on each axis
  logic              s2_valid_q;
  obot_pkg::dot_t    s2_du_q [NA][NB];
  obot_pkg::dot_t    s2_dv_q [NA][NB];
  obot_pkg::dist_t   s2_dd_q [NA];
  obot_pkg::ext_t    s2_w_q  [NB];
  obot_pkg::ext_t    s2_h_q  [NB];

  obot_pkg::dot_t    s2_du_d [NA][NB];
  obot_pkg::dot_t    s2_dv_d [NA][NB];
  obot_pkg::dist_t   s2_dd_d [NA];

  always_comb begin
    for (int k = 0; k < NA; k++) begin
      s2_dd_d[k] = obot_pkg::DistW'(s1_dx_q) * obot_pkg::DistW'(s1_ax_q[k])
                 + obot_pkg::DistW'(s1_dy_q) * obot_pkg::DistW'(s1_ay_q[k]);
      for (int b = 0; b < NB; b++) begin
        s2_du_d[k][b] = obot_pkg::DotW'(s1_c_q[b]) * obot_pkg::DotW'(s1_ax_q[k])
                      + obot_pkg::DotW'(s1_s_q[b]) * obot_pkg::DotW'(s1_ay_q[k]);
        s2_dv_d[k][b] = obot_pkg::DotW'(s1_c_q[b]) * obot_pkg::DotW'(s1_ay_q[k])
                      - obot_pkg::DotW'(s1_s_q[b]) * obot_pkg::DotW'(s1_ax_q[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s2_du_q <= s2_du_d;
    s2_dv_q <= s2_dv_d;
    s2_dd_q <= s2_dd_d;
    s2_w_q  <= s1_w_q;
    s2_h_q  <= s1_h_q;
  end

  // stage 3: scale by half extents, absolute center distance
  logic              s3_valid_q;
  obot_pkg::prod_t   s3_pu_q [NA][NB];
  obot_pkg::prod_t   s3_pv_q [NA][NB];
  obot_pkg::absd_t   s3_ad_q [NA];

  obot_pkg::prod_t   s3_pu_d [NA][NB];
  obot_pkg::prod_t   s3_pv_d [NA][NB];
  obot_pkg::absd_t   s3_ad_d [NA];

  always_comb begin
    for (int k = 0; k < NA; k++) begin
      s3_ad_d[k] = s2_dd_q[k][obot_pkg::DistW-1]
                 ? obot_pkg::AbsDW'(-s2_dd_q[k]) : obot_pkg::AbsDW'(s2_dd_q[k]);
      for (int b = 0; b < NB; b++) begin
        s3_pu_d[k][b] = obot_pkg::ProdW'(s2_du_q[k][b])
                      * obot_pkg::ProdW'(signed'({1'b0, s2_w_q[b]}));
        s3_pv_d[k][b] = obot_pkg::ProdW'(s2_dv_q[k][b])
                      * obot_pkg::ProdW'(signed'({1'b0, s2_h_q[b]}));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s3_pu_q <= s3_pu_d;
    s3_pv_q <= s3_pv_d;
    s3_ad_q <= s3_ad_d;
  end

  // stage 4: magnitudes
  logic              s4_valid_q;
  obot_pkg::mag_t    s4_mu_q [NA][NB];
  obot_pkg::mag_t    s4_mv_q [NA][NB];
  obot_pkg::absd_t   s4_ad_q [NA];

  obot_pkg::mag_t    s4_mu_d [NA][NB];
  obot_pkg::mag_t    s4_mv_d [NA][NB];

  always_comb begin
    for (int k = 0; k < NA; k++) begin
      for (int b = 0; b < NB; b++) begin
        s4_mu_d[k][b] = s3_pu_q[k][b][obot_pkg::ProdW-1]
                      ? obot_pkg::MagW'(-s3_pu_q[k][b]) : obot_pkg::MagW'(s3_pu_q[k][b]);
        s4_mv_d[k][b] = s3_pv_q[k][b][obot_pkg::ProdW-1]
                      ? obot_pkg::MagW'(-s3_pv_q[k][b]) : obot_pkg::MagW'(s3_pv_q[k][b]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s4_mu_q <= s4_mu_d;
    s4_mv_q <= s4_mv_d;
    s4_ad_q <= s3_ad_q;
  end

  // stage 5: combined interval radius per axis
  logic              s5_valid_q;
  obot_pkg::rad_t    s5_r_q  [NA];
  obot_pkg::absd_t   s5_ad_q [NA];

  obot_pkg::rad_t    s5_r_d  [NA];

  always_comb begin
    for (int k = 0; k < NA; k++) begin
      s5_r_d[k] = obot_pkg::RadW'(s4_mu_q[k][0]) + obot_pkg::RadW'(s4_mv_q[k][0])
                + obot_pkg::RadW'(s4_mu_q[k][1]) + obot_pkg::RadW'(s4_mv_q[k][1]);
    end
  end

  always_ff @(posedge clk_i) begin
    s5_r_q  <= s5_r_d;
    s5_ad_q <= s4_ad_q;
  end

  // stage 6: separation compare, touching counts as apart
  logic [NA-1:0] sep;
  logic          boxes_overlap_q, boxes_overlap_d;

  always_comb begin
    for (int k = 0; k < NA; k++) begin
      sep[k] = obot_pkg::RadW'({s5_ad_q[k], {obot_pkg::FracSh{1'b0}}}) >= s5_r_q[k];
    end
    boxes_overlap_d = ~|sep;
  end

  always_ff @(posedge clk_i) begin
    boxes_overlap_q <= boxes_overlap_d;
  end

  logic done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
      s5_valid_q <= s4_valid_q;
      done_q     <= s5_valid_q;
    end
  end

  assign done_o          = done_q;
  assign boxes_overlap_o = boxes_overlap_q;

  `OBOT_ASSERT_NEXT(a_accept_enters, accept, s1_valid_q, "transfer did not enter the pipe")
  `OBOT_ASSERT_SAME(a_done_has_source, done_o, $past(start, obot_pkg::Latency), "done without start")
  `OBOT_ASSERT_SAME(a_zero_axis_apart, s1_valid_q && s1_ax_q[0] == '0 && s1_ay_q[0] == '0, ##5 (done_o && !boxes_overlap_o), "zero axis reported overlap")
  `OBOT_ASSERT_SAME(a_sep_clears_overlap, s5_valid_q && sep != '0, ##1 (done_o && !boxes_overlap_o), "separating axis ignored")

endmodule

// File: sim/tb_oriented_box_overlap_test.sv
`timescale 1ns / 1ps

module tb_oriented_box_overlap_test;

  typedef struct packed {
    obot_pkg::center_t center_x;
    obot_pkg::center_t center_y;
    obot_pkg::rot_t    cosine;
    obot_pkg::rot_t    sine;
    obot_pkg::ext_t    half_width;
    obot_pkg::ext_t    half_height;
  } box_t;

  localparam int NumRandom = 1200;
  localparam int MaxReports = 10;
  localparam int BoxW = $bits(box_t);

  class overlap_scoreboard;
    bit expected_q[$];
    int mismatches;
    int strays;
    int checked;
    int overlaps;

    // Interval of box b projected on the unnormalized axis (ax, ay).
    function automatic void box_span(box_t b, longint ax, longint ay,
                                     output longint lo, output longint hi);
      longint cx, cy, c, s, w, h, lx, ly, px, py, p;
      int k;
      cx = longint'(b.center_x);
      cy = longint'(b.center_y);
      c  = longint'(b.cosine);
      s  = longint'(b.sine);
      w  = longint'(b.half_width);
      h  = longint'(b.half_height);
      lo = 0;
      hi = 0;
      for (k = 0; k < 4; k++) begin
        lx = (k == 1 || k == 2) ? w : -w;
        ly = (k >= 2) ? h : -h;
        px = cx * 16384 + c * lx - s * ly;
        py = cy * 16384 + s * lx + c * ly;
        p  = px * ax + py * ay;
        if (k == 0) begin
          lo = p;
          hi = p;
        end else begin
          if (p < lo) lo = p;
          if (p > hi) hi = p;
        end
      end
    endfunction

    function automatic bit predict_overlap(box_t a, box_t b);
      longint axx[4], axy[4];
      longint lo_a, hi_a, lo_b, hi_b;
      int i;
      axx[0] = (a.half_width != 0)  ? longint'(a.cosine) : 0;
      axy[0] = (a.half_width != 0)  ? longint'(a.sine) : 0;
      axx[1] = (a.half_height != 0) ? -longint'(a.sine) : 0;
      axy[1] = (a.half_height != 0) ? longint'(a.cosine) : 0;
      axx[2] = (b.half_width != 0)  ? longint'(b.cosine) : 0;
      axy[2] = (b.half_width != 0)  ? longint'(b.sine) : 0;
      axx[3] = (b.half_height != 0) ? -longint'(b.sine) : 0;
      axy[3] = (b.half_height != 0) ? longint'(b.cosine) : 0;
      for (i = 0; i < 4; i++) begin
        box_span(a, axx[i], axy[i], lo_a, hi_a);
        box_span(b, axx[i], axy[i], lo_b, hi_b);
        if (lo_a >= hi_b || lo_b >= hi_a) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_pair(box_t a, box_t b);
      expected_q.push_back(predict_overlap(a, b));
    endfunction

    function void check_result(logic got);
      bit want;
      if (expected_q.size() == 0) begin
        strays++;
        if (strays + mismatches <= MaxReports)
          $display("%0t: result %b with no transfer pending", $realtime, got);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (want) overlaps++;
      if (got !== want) begin
        mismatches++;
        if (strays + mismatches <= MaxReports)
          $display("%0t: result %0d boxes_overlap expected %b got %b",
                   $realtime, checked - 1, want, got);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function int failures();
      return mismatches + strays;
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  obot_pkg::center_t first_center_x_i, first_center_y_i, second_center_x_i, second_center_y_i;
  obot_pkg::rot_t    first_cosine_i, first_sine_i, second_cosine_i, second_sine_i;
  obot_pkg::ext_t    first_half_width_i, first_half_height_i;
  obot_pkg::ext_t    second_half_width_i, second_half_height_i;
  logic              done_o;
  logic              boxes_overlap_o;

  overlap_scoreboard sb = new;
  bit idle_on;
  int directed_cnt;

  oriented_box_overlap_test u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .first_center_x_i    (first_center_x_i),
    .first_center_y_i    (first_center_y_i),
    .first_cosine_i      (first_cosine_i),
    .first_sine_i        (first_sine_i),
    .first_half_width_i  (first_half_width_i),
    .first_half_height_i (first_half_height_i),
    .second_center_x_i   (second_center_x_i),
    .second_center_y_i   (second_center_y_i),
    .second_cosine_i     (second_cosine_i),
    .second_sine_i       (second_sine_i),
    .second_half_width_i (second_half_width_i),
    .second_half_height_i(second_half_height_i),
    .done_o              (done_o),
    .boxes_overlap_o     (boxes_overlap_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o !== 1'b0) sb.check_result(boxes_overlap_o);
  end

  function automatic box_t mk_box(int cx, int cy, int c, int s, int w, int h);
    box_t b;
    b.center_x    = obot_pkg::center_t'(cx);
    b.center_y    = obot_pkg::center_t'(cy);
    b.cosine      = obot_pkg::rot_t'(c);
    b.sine        = obot_pkg::rot_t'(s);
    b.half_width  = obot_pkg::ext_t'(w);
    b.half_height = obot_pkg::ext_t'(h);
    return b;
  endfunction

  function automatic void rand_rotation(output obot_pkg::rot_t c, output obot_pkg::rot_t s);
    real ang;
    ang = $urandom_range(0, 62831) / 10000.0;
    c = obot_pkg::rot_t'($rtoi($cos(ang) * 16384.0));
    s = obot_pkg::rot_t'($rtoi($sin(ang) * 16384.0));
  endfunction

  function automatic int rand_ext(int ext_max);
    if ($urandom_range(0, 32) == 0) return 0;
    return int'($urandom_range(1, ext_max));
  endfunction

  task automatic send_pair(box_t a, box_t b);
    int gap;
    gap = idle_on ? int'($urandom_range(0, 7)) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    first_center_x_i     <= a.center_x;
    first_center_y_i     <= a.center_y;
    first_cosine_i       <= a.cosine;
    first_sine_i         <= a.sine;
    first_half_width_i   <= a.half_width;
    first_half_height_i  <= a.half_height;
    second_center_x_i    <= b.center_x;
    second_center_y_i    <= b.center_y;
    second_cosine_i      <= b.cosine;
    second_sine_i        <= b.sine;
    second_half_width_i  <= b.half_width;
    second_half_height_i <= b.half_height;
    start <= 1'b1;
    do @(posedge clk_i); while (busy !== 1'b0);
    sb.note_pair(a, b);
  endtask

  // Hold off the sender until every pending result has come back.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic send_random_pair();
    box_t a, b;
    int kind, ext_max, reach, dx, dy, sgn;
    kind = int'($urandom_range(0, 99));
    if (kind < 15) begin
      a = box_t'(BoxW'({$urandom, $urandom, $urandom, $urandom}));
      b = box_t'(BoxW'({$urandom, $urandom, $urandom, $urandom}));
    end else if (kind < 27) begin
      // axis-aligned pair placed edge to edge, one unit either way
      a = mk_box(int'($urandom_range(0, 4194303)) - 2097152,
                 int'($urandom_range(0, 4194303)) - 2097152,
                 $urandom_range(0, 1) ? 16384 : -16384, 0,
                 int'($urandom_range(1, 4095)), int'($urandom_range(1, 4095)));
      b = mk_box(0, 0, $urandom_range(0, 1) ? 16384 : -16384, 0,
                 int'($urandom_range(1, 4095)), int'($urandom_range(1, 4095)));
      sgn = $urandom_range(0, 1) ? 1 : -1;
      dx = sgn * int'(a.half_width + b.half_width) + int'($urandom_range(0, 2)) - 1;
      reach = int'(a.half_height + b.half_height);
      dy = int'($urandom_range(0, 2 * reach)) - reach;
      if ($urandom_range(0, 1)) begin
        b.center_x = obot_pkg::center_t'(int'(a.center_x) + dx);
        b.center_y = obot_pkg::center_t'(int'(a.center_y) + dy);
      end else begin
        // same contact along y, axes swapped in their roles
        b.half_width  = a.half_width;
        b.center_x    = obot_pkg::center_t'(int'(a.center_x) + dy % (int'(a.half_width) + 1));
        b.center_y    = obot_pkg::center_t'(int'(a.center_y) + sgn * int'(a.half_height
                        + b.half_height) + int'($urandom_range(0, 2)) - 1);
      end
    end else begin
      ext_max = ($urandom_range(0, 19) == 0) ? 2097151 : 4095;
      a.center_x = obot_pkg::center_t'(int'($urandom_range(0, 8388607)) - 4194304);
      a.center_y = obot_pkg::center_t'(int'($urandom_range(0, 8388607)) - 4194304);
      a.half_width  = obot_pkg::ext_t'(rand_ext(ext_max));
      a.half_height = obot_pkg::ext_t'(rand_ext(ext_max));
      b.half_width  = obot_pkg::ext_t'(rand_ext(ext_max));
      b.half_height = obot_pkg::ext_t'(rand_ext(ext_max));
      rand_rotation(a.cosine, a.sine);
      rand_rotation(b.cosine, b.sine);
      if ($urandom_range(0, 29) == 0) begin
        a.cosine = obot_pkg::rot_t'($urandom);
        b.sine   = obot_pkg::rot_t'($urandom);
      end
      reach = int'(a.half_width) + int'(a.half_height)
            + int'(b.half_width) + int'(b.half_height);
      dx = int'($urandom_range(0, 3 * reach)) - 3 * reach / 2;
      dy = int'($urandom_range(0, 3 * reach)) - 3 * reach / 2;
      b.center_x = obot_pkg::center_t'(int'(a.center_x) + dx);
      b.center_y = obot_pkg::center_t'(int'(a.center_y) + dy);
    end
    send_pair(a, b);
  endtask

  initial begin
    int i;
    rst_ni               = 1'b0;
    start                = 1'b0;
    first_center_x_i     = '0;
    first_center_y_i     = '0;
    first_cosine_i       = '0;
    first_sine_i         = '0;
    first_half_width_i   = '0;
    first_half_height_i  = '0;
    second_center_x_i    = '0;
    second_center_y_i    = '0;
    second_cosine_i      = '0;
    second_sine_i        = '0;
    second_half_width_i  = '0;
    second_half_height_i = '0;
    idle_on              = 1'b1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corner cases
    send_pair(mk_box(0, 0, 16384, 0, 256, 256), mk_box(0, 0, 16384, 0, 256, 256));
    send_pair(mk_box(0, 0, 16384, 0, 0, 256), mk_box(0, 0, 16384, 0, 256, 256));
    send_pair(mk_box(0, 0, 16384, 0, 256, 256), mk_box(10, 10, 0, 16384, 256, 0));
    send_pair(mk_box(0, 0, 0, 0, 256, 256), mk_box(0, 0, 16384, 0, 256, 256));
    send_pair(mk_box(0, 0, -32768, 32767, 512, 300),
              mk_box(100, -50, 32767, -32768, 400, 700));
    send_pair(mk_box(8388607, 8388607, 16384, 0, 4194303, 4194303),
              mk_box(-8388608, -8388608, 16384, 0, 4194303, 4194303));
    send_pair(mk_box(-8388608, -8388608, 0, -16384, 4194303, 4194303),
              mk_box(-8388608, 8388607, -16384, 0, 4194303, 4194303));
    send_pair(mk_box(8388607, -8388608, -16384, 16384, 4194303, 1),
              mk_box(-8388608, 8388607, 16384, -16384, 1, 4194303));
    send_pair(mk_box(0, 0, 16384, 0, 256, 256), mk_box(512, 0, 16384, 0, 256, 256));
    send_pair(mk_box(0, 0, 16384, 0, 256, 256), mk_box(511, 0, 16384, 0, 256, 256));
    send_pair(mk_box(0, 0, 16384, 0, 256, 256), mk_box(0, -512, -16384, 0, 256, 256));
    send_pair(mk_box(0, 0, 11585, 11585, 256, 256), mk_box(600, 0, 16384, 0, 256, 256));
    send_pair(mk_box(0, 0, 11585, 11585, 256, 256), mk_box(700, 0, 16384, 0, 256, 256));
    send_pair(mk_box(0, 0, -1, -1, 4194303, 4194303), mk_box(-1, -1, -1, -1, 4194303, 1));
    send_pair(mk_box(1000, 1000, 16384, 0, 4000, 4000),
              mk_box(1200, 900, 11585, -11585, 10, 20));
    send_pair(mk_box(0, 0, 16384, 16384, 256, 256), mk_box(0, 0, -16384, -16384, 1, 1));
    directed_cnt = 16;
    drain();

    for (i = 0; i < NumRandom; i++) begin
      if (i % 100 == 0) idle_on = ($urandom_range(0, 2) != 0);
      if (i % 300 == 150) drain();
      send_random_pair();
    end

    drain();
    repeat (obot_pkg::Latency + 4) @(posedge clk_i);
    $display("Box pair tests: %0d directed and %0d random transfers, %0d results checked",
             directed_cnt, NumRandom, sb.checked);
    $display("  %0d reported overlapping, %0d separated or touching; %0d mismatches",
             sb.overlaps, sb.checked - sb.overlaps, sb.failures());
    if (sb.failures() == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
